// ===== rtl/ppmcrsf_pkg.sv =====
// Package with the shared types, constants and functions of the PPM to CRSF frame encoder.
`default_nettype none

package ppmcrsf_pkg;

  // Number of PPM channel slots that are measured and stored.
  localparam int PPM_CHANNELS = 8;
  localparam int SLOT_W       = (PPM_CHANNELS > 1) ? $clog2(PPM_CHANNELS) : 1;
  localparam int SLOT_CNT_W   = $clog2(PPM_CHANNELS + 1);

  localparam int CRSF_CHANNELS = 16;
  localparam int CH_IDX_W      = $clog2(CRSF_CHANNELS);
  localparam int CH_BITS       = 11;
  localparam int WIDTH_W       = 12;
  localparam int PROD_W        = 23;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_BYTE  = 2'd0;
  localparam logic [1:0] CFG_SYNC_GAP   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  // Reset values of the configuration registers and the slots.
  localparam logic [7:0]         SYNC_BYTE_RST = 8'd200;
  localparam logic [15:0]        SYNC_GAP_RST  = 16'd3000;
  localparam logic [31:0]        TIMEOUT_RST   = 32'd500000;
  localparam logic [WIDTH_W-1:0] WIDTH_RST     = 12'd1500;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX     = 12'd4095;

  // Frame constants.
  localparam logic [7:0] FRAME_LEN_BYTE = 8'd24;
  localparam logic [7:0] FRAME_TYPE     = 8'h16;
  localparam logic [7:0] CRC_POLY       = 8'hD5;

  // Channel mapping constants.
  localparam logic [WIDTH_W-1:0] MAP_OFFSET = 12'd988;
  localparam logic [10:0]        MAP_SCALE  = 11'd1639;
  localparam logic [10:0]        CH_MIN     = 11'd172;
  localparam logic [10:0]        CH_MAX     = 11'd1811;
  localparam logic [10:0]        CH_IDLE    = 11'd992;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_MUL,
    ST_ADD,
    ST_DRAIN,
    ST_CRC
  } state_e;

  // One byte of CRC-8, MSB first, eight shift steps.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppmcrsf_if.sv =====
// Valid/ready channel interfaces for events, frame bytes and configuration writes.
`default_nettype none

interface ppmcrsf_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] time_us;
  modport source (output valid, operation, time_us, input ready);
  modport sink   (input valid, operation, time_us, output ready);
endinterface

interface ppmcrsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface ppmcrsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppmcrsf_map.sv =====
// Channel mapping unit: registered width multiply, then offset add and clamp.
`default_nettype none

module ppmcrsf_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [ppmcrsf_pkg::WIDTH_W-1:0] width_i,
  input  logic                        is_ppm_i,
  output logic [ppmcrsf_pkg::CH_BITS-1:0] value_o
);
  import ppmcrsf_pkg::*;

  logic [PROD_W-1:0]  prod_d, prod_q;
  logic               short_d, short_q;
  logic               ppm_q;
  logic [WIDTH_W-1:0] diff;
  logic [13:0]        sum;

  assign short_d = (width_i <= MAP_OFFSET);
  assign diff    = width_i - MAP_OFFSET;
  assign prod_d  = PROD_W'(diff) * PROD_W'(MAP_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q   <= 1'b0;
      short_q <= 1'b1;
    end else if (load_i) begin
      ppm_q   <= is_ppm_i;
      short_q <= short_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // The scaled value is the product divided by 1024, plus the low end of the range.
  assign sum = 14'(prod_q[PROD_W-1:10]) + 14'(CH_MIN);

  always_comb begin
    if (!ppm_q) begin
      value_o = CH_IDLE;
    end else if (short_q) begin
      value_o = CH_MIN;
    end else if (sum > 14'(CH_MAX)) begin
      value_o = CH_MAX;
    end else begin
      value_o = sum[CH_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppm_to_crsf_frame_encoder_top.sv =====
// Top level of the PPM to CRSF frame encoder: edge timing, channel slots and frame sequencer.
//
//   Channel  Direction  Beat carries
//   in_i     sink       operation (edge or send), time_us
//   cfg_i    sink       index, data (sync byte, sync gap, signal timeout)
//   out_o    source     frame_byte, last_byte
//
// An edge beat is absorbed in the cycle it is accepted, and the block stays ready for
// the next beat. A send beat whose last edge is stale is dropped without a frame. A fresh
// send runs the frame sequencer: three header bytes, then for each of the 16 channels
// a multiply step, a pack step, a drain step per byte that leaves the bit buffer and a
// turn step, then the CRC byte. The shared mapping multiplier and the one-byte output
// register set the pace of this sequence; out_o stalls hold it at a header, data or
// CRC byte. Reset puts every slot at 1500 us and the registers at their defaults.
`default_nettype none

module ppm_to_crsf_frame_encoder_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  ppmcrsf_in_if.sink    in_i,
  ppmcrsf_cfg_if.sink   cfg_i,
  ppmcrsf_out_if.source out_o
);
  import ppmcrsf_pkg::*;

  // Configuration registers.
  logic [7:0]  sync_byte_q;
  logic [15:0] sync_gap_q;
  logic [31:0] timeout_q;

  // Edge timing state.
  logic [WIDTH_W-1:0]    width_q [PPM_CHANNELS];
  logic [SLOT_CNT_W-1:0] slot_q;
  logic [31:0]           last_edge_q;

  // Sequencer state.
  state_e              state_q, state_d;
  logic [1:0]          hdr_q, hdr_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic [17:0]         acc_q, acc_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [7:0]          crc_q, crc_d;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic        in_fire, edge_fire, send_fire, fresh;
  logic [31:0] diff;
  logic        can_push, push;
  logic [7:0]  push_byte;
  logic        push_last;
  logic        map_load, ch_is_ppm;
  logic [CH_BITS-1:0] map_value;
  logic        cnt_has_byte, ch_last;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign edge_fire   = in_fire && !in_i.operation;
  assign send_fire   = in_fire && in_i.operation;

  // One subtractor serves both the edge gap and the signal age.
  assign diff  = in_i.time_us - last_edge_q;
  assign fresh = (diff < timeout_q);

  assign can_push     = !out_valid_q || out_o.ready;
  assign cnt_has_byte = (cnt_q >= 5'd8);
  assign ch_last      = (ch_q == CH_IDX_W'(CRSF_CHANNELS - 1));
  assign ch_is_ppm    = (int'(ch_q) < PPM_CHANNELS);

  ppmcrsf_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (map_load),
    .width_i  (width_q[ch_q[SLOT_W-1:0]]),
    .is_ppm_i (ch_is_ppm),
    .value_o  (map_value)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (send_fire && fresh) begin
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        if (can_push && hdr_q == 2'd2) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (!cnt_has_byte) begin
          state_d = ch_last ? ST_CRC : ST_MUL;
        end
      end
      ST_CRC: begin
        if (can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and datapath.
  always_comb begin
    hdr_d     = hdr_q;
    ch_d      = ch_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    push      = 1'b0;
    push_byte = acc_q[7:0];
    push_last = 1'b0;
    map_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        hdr_d = 2'd0;
        ch_d  = '0;
        acc_d = '0;
        cnt_d = '0;
        crc_d = '0;
      end
      ST_HDR: begin
        push = can_push;
        case (hdr_q)
          2'd0:    push_byte = sync_byte_q;
          2'd1:    push_byte = FRAME_LEN_BYTE;
          default: push_byte = FRAME_TYPE;
        endcase
        if (can_push) begin
          hdr_d = hdr_q + 2'd1;
          if (hdr_q == 2'd2) begin
            crc_d = crc_step(crc_q, FRAME_TYPE);
          end
        end
      end
      ST_MUL: map_load = 1'b1;
      ST_ADD: begin
        acc_d = acc_q | (18'(map_value) << cnt_q);
        cnt_d = cnt_q + 5'(CH_BITS);
      end
      ST_DRAIN: begin
        if (cnt_has_byte) begin
          push = can_push;
          if (can_push) begin
            acc_d = acc_q >> 8;
            cnt_d = cnt_q - 5'd8;
            crc_d = crc_step(crc_q, acc_q[7:0]);
          end
        end else if (!ch_last) begin
          ch_d = ch_q + CH_IDX_W'(1);
        end
      end
      ST_CRC: begin
        push      = can_push;
        push_byte = crc_q;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hdr_q       <= 2'd0;
      ch_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hdr_q   <= hdr_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    crc_q <= crc_d;
    if (push) begin
      out_byte_q <= push_byte;
      out_last_q <= push_last;
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q <= SYNC_BYTE_RST;
      sync_gap_q  <= SYNC_GAP_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SYNC_BYTE: sync_byte_q <= cfg_i.data[7:0];
        CFG_SYNC_GAP:  sync_gap_q  <= cfg_i.data[15:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Edge handling: a long gap restarts at slot zero, a short one fills the next slot
  // with the gap saturated to twelve bits, and once all slots are full it is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      last_edge_q <= '0;
      for (int i = 0; i < PPM_CHANNELS; i++) begin
        width_q[i] <= WIDTH_RST;
      end
    end else if (edge_fire) begin
      last_edge_q <= in_i.time_us;
      if (diff > 32'(sync_gap_q)) begin
        slot_q <= '0;
      end else if (int'(slot_q) < PPM_CHANNELS) begin
        width_q[slot_q[SLOT_W-1:0]] <= (diff > 32'(WIDTH_MAX)) ? WIDTH_MAX
                                                               : diff[WIDTH_W-1:0];
        slot_q <= slot_q + SLOT_CNT_W'(1);
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.frame_byte = out_byte_q;
  assign out_o.last_byte  = out_last_q;

endmodule

`default_nettype wire
